// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock and reset are the block's own
// clock and synchronous active-high reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold whenever the antecedent holds in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sord_pkg.sv =====
`timescale 1ns / 1ps

package sord_pkg;

   // Sizing
   localparam int MAX_TARGETS     = 64;
   localparam int MAX_HALT_FRAMES = 32;
   localparam int COORD_BITS      = 12;
   localparam int ID_BITS         = 6;
   localparam int TGT_BITS        = $clog2(MAX_TARGETS);
   localparam int SLOT_BITS       = $clog2(MAX_HALT_FRAMES);
   localparam int COUNT_BITS      = $clog2(MAX_HALT_FRAMES + 1);
   localparam int HF_BITS         = 6;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 12;
   localparam int BOX_ADDR_BITS   = TGT_BITS + SLOT_BITS;

   // Register indexes of the CSR port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REGION_X       = 3'd0,
      CSR_REGION_Y       = 3'd1,
      CSR_REGION_W       = 3'd2,
      CSR_REGION_H       = 3'd3,
      CSR_HALT_FRAMES    = 3'd4,
      CSR_HALT_THRESHOLD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } box_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    target_id;
      logic [COORD_BITS-1:0] box_x;
      logic [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-1:0] box_w;
      logic [COORD_BITS-1:0] box_h;
      logic                  frame_start;
      logic                  new_track;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] echo_id;
      logic               in_region;
      logic               halt_event;
   } rsp_type;

   // Per-target ring pointer and fill level
   typedef struct packed {
      logic [SLOT_BITS-1:0]  head;
      logic [COUNT_BITS-1:0] count;
   } meta_type;

   // Sequencer requests to the history store
   typedef struct packed {
      logic                 meta_rd_en;
      logic [TGT_BITS-1:0]  meta_rd_id;
      logic                 meta_wr_en;
      logic [TGT_BITS-1:0]  meta_wr_id;
      meta_type             meta_wr;
      logic                 box_wr_en;
      logic                 box_rd_en;
      logic [TGT_BITS-1:0]  box_id;
      logic [SLOT_BITS-1:0] box_wr_slot;
      logic [SLOT_BITS-1:0] box_rd_slot;
   } hist_ctl_type;

endpackage

// ===== rtl/sord_cmp.sv =====
`timescale 1ns / 1ps

// Shared box compare unit: flags any coordinate that moved past the threshold.
module sord_cmp (
   input  sord_pkg::box_type               cur_box,
   input  sord_pkg::box_type               old_box,
   input  logic [sord_pkg::COORD_BITS-1:0] threshold,
   output logic                            fail
);
   import sord_pkg::*;

   function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   // One box per call, four coordinates side by side
   always_comb begin
      fail = (absdiff(cur_box.x, old_box.x) > threshold) ||
             (absdiff(cur_box.y, old_box.y) > threshold) ||
             (absdiff(cur_box.w, old_box.w) > threshold) ||
             (absdiff(cur_box.h, old_box.h) > threshold);
   end

endmodule

// ===== rtl/sord_history.sv =====
`timescale 1ns / 1ps

// Box history RAM plus per-target head/count RAM with valid bits.
module sord_history (
   input  logic                   clock,
   input  logic                   reset,
   input  sord_pkg::hist_ctl_type ctl,
   input  sord_pkg::box_type      box_wr_data,
   output sord_pkg::box_type      box_rd_data,
   output sord_pkg::meta_type     meta_rd_data
);
   import sord_pkg::*;

   box_type                box_mem [MAX_TARGETS*MAX_HALT_FRAMES];
   meta_type               meta_mem [MAX_TARGETS];
   logic [MAX_TARGETS-1:0] meta_vld_ff;
   logic [MAX_TARGETS-1:0] meta_vld_in;
   box_type                box_q_ff;
   meta_type               meta_q_ff;
   logic                   meta_q_vld_ff;

   // Box ring storage, one read and one write port
   always_ff @(posedge clock) begin
      if (ctl.box_wr_en) begin
         box_mem[{ctl.box_id, ctl.box_wr_slot}] <= box_wr_data;
      end
      if (ctl.box_rd_en) begin
         box_q_ff <= box_mem[{ctl.box_id, ctl.box_rd_slot}];
      end
   end

   assign box_rd_data = box_q_ff;

   // Head/count storage
   always_ff @(posedge clock) begin
      if (ctl.meta_wr_en) begin
         meta_mem[ctl.meta_wr_id] <= ctl.meta_wr;
      end
      if (ctl.meta_rd_en) begin
         meta_q_ff <= meta_mem[ctl.meta_rd_id];
      end
   end

   // Valid bits: an unwritten slot reads as zero head and count
   always_comb begin
      meta_vld_in = meta_vld_ff;
      if (ctl.meta_wr_en) begin
         meta_vld_in[ctl.meta_wr_id] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_vld_ff   <= '0;
         meta_q_vld_ff <= 1'b0;
      end else begin
         meta_vld_ff <= meta_vld_in;
         if (ctl.meta_rd_en) begin
            meta_q_vld_ff <= meta_vld_ff[ctl.meta_rd_id];
         end
      end
   end

   assign meta_rd_data = meta_q_vld_ff ? meta_q_ff : '0;

endmodule

// ===== rtl/stopped_object_region_detector.sv =====
`timescale 1ns / 1ps
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   req_type: target box, frame/track flags
//  rsp      out        rsp_valid / rsp_stall   rsp_type: id, in_region, halt_event
//  csr      in         csr_valid / csr_ready   csr_index, csr_wdata
//
//  One transaction at a time: no new request is accepted until the last result
//  is loaded into the output register, and a moved box ends a scan early;
//  the single read port of the box history RAM feeds the compare unit one
//  stored box per cycle.
//  Synchronous reset sets config to defaults, clears membership flags and history valid
//  bits; no clearing pass is needed. A stalled result holds in the output register.

`include "assert_macros.svh"

module stopped_object_region_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sord_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sord_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sord_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sord_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sord_pkg::*;

   localparam int PT_BITS   = COORD_BITS + 3;
   localparam int WIDE_BITS = ((HF_BITS > COUNT_BITS) ? HF_BITS : COUNT_BITS) + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_META = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   req_type                item_ff, item_in;
   logic [MAX_TARGETS-1:0] prev_ff, prev_in;
   logic [MAX_TARGETS-1:0] this_ff, this_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [COUNT_BITS-1:0]  left_ff, left_in;
   logic                   pend_ff, pend_in;
   logic                   res_inside_ff, res_inside_in;
   logic                   res_halt_ff, res_halt_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [COORD_BITS-1:0]  region_x_ff, region_y_ff, region_w_ff, region_h_ff;
   logic [HF_BITS-1:0]     halt_frames_ff;
   logic [COORD_BITS-1:0]  halt_threshold_ff;

   hist_ctl_type           ctl;
   box_type                cur_box;
   box_type                old_box;
   meta_type               meta_rd;
   meta_type               meta_eff;
   logic [SLOT_BITS-1:0]   head_new;
   logic [COUNT_BITS-1:0]  cnt_new;
   logic [TGT_BITS-1:0]    tgt;
   logic                   id_ok;
   logic                   req_fire;
   logic                   cmp_fail;
   logic                   in_zone;
   logic                   newly;
   logic signed [PT_BITS-1:0] px, py, rx0, rx1, ry0, ry1;

   // CSR writes: the user must see that they are only issued while idle; the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_x_ff       <= COORD_BITS'(0);
         region_y_ff       <= COORD_BITS'(0);
         region_w_ff       <= COORD_BITS'(4095);
         region_h_ff       <= COORD_BITS'(4095);
         halt_frames_ff    <= HF_BITS'(8);
         halt_threshold_ff <= COORD_BITS'(2);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REGION_X:       region_x_ff       <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_Y:       region_y_ff       <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_W:       region_w_ff       <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_H:       region_h_ff       <= csr_wdata[COORD_BITS-1:0];
            CSR_HALT_FRAMES:    halt_frames_ff    <= csr_wdata[HF_BITS-1:0];
            CSR_HALT_THRESHOLD: halt_threshold_ff <= csr_wdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Datapath helpers
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign tgt       = item_ff.target_id[TGT_BITS-1:0];
   assign id_ok     = (32'(item_ff.target_id) < MAX_TARGETS);
   assign cur_box   = '{x: item_ff.box_x, y: item_ff.box_y,
                        w: item_ff.box_w, h: item_ff.box_h};

   assign meta_eff = item_ff.new_track ? '0 : meta_rd;
   assign head_new = (32'(meta_eff.head) == MAX_HALT_FRAMES - 1) ? '0
                     : meta_eff.head + SLOT_BITS'(1);
   assign cnt_new  = (meta_eff.count < COUNT_BITS'(MAX_HALT_FRAMES))
                     ? meta_eff.count + COUNT_BITS'(1) : meta_eff.count;

   // Bottom-centre point against the half-open region
   always_comb begin
      px  = $signed(PT_BITS'(item_ff.box_x)) + $signed(PT_BITS'(item_ff.box_w >> 1))
            - $signed(PT_BITS'(1));
      py  = $signed(PT_BITS'(item_ff.box_y)) + $signed(PT_BITS'(item_ff.box_h))
            - $signed(PT_BITS'(1));
      rx0 = $signed(PT_BITS'(region_x_ff));
      ry0 = $signed(PT_BITS'(region_y_ff));
      rx1 = rx0 + $signed(PT_BITS'(region_w_ff));
      ry1 = ry0 + $signed(PT_BITS'(region_h_ff));
      in_zone = (rx0 <= px) && (px < rx1) && (ry0 <= py) && (py < ry1);
   end

   assign newly = in_zone && !prev_ff[tgt];

   // History store and shared compare unit
   sord_history u_history (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .box_wr_data  (cur_box),
      .box_rd_data  (old_box),
      .meta_rd_data (meta_rd)
   );

   sord_cmp u_cmp (
      .cur_box   (cur_box),
      .old_box   (old_box),
      .threshold (halt_threshold_ff),
      .fail      (cmp_fail)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      prev_in       = prev_ff;
      this_in       = this_ff;
      slot_in       = slot_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      res_inside_in = res_inside_ff;
      res_halt_in   = res_halt_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      ctl             = '0;
      ctl.meta_rd_id  = req_data.target_id[TGT_BITS-1:0];
      ctl.meta_wr_id  = tgt;
      ctl.meta_wr     = '{head: head_new, count: cnt_new};
      ctl.box_id      = tgt;
      ctl.box_wr_slot = meta_eff.head;
      ctl.box_rd_slot = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               item_in        = req_data;
               ctl.meta_rd_en = 1'b1;
               // frame roll of the membership flags
               if (req_data.frame_start) begin
                  prev_in = this_ff;
                  this_in = '0;
               end
               state_in = S_META;
            end
         end
         S_META: begin
            ctl.meta_wr_en = id_ok;
            ctl.box_wr_en  = id_ok;
            res_inside_in  = in_zone && id_ok;
            res_halt_in    = 1'b0;
            slot_in        = (meta_eff.head == '0) ? SLOT_BITS'(MAX_HALT_FRAMES - 1)
                             : meta_eff.head - SLOT_BITS'(1);
            left_in        = COUNT_BITS'(halt_frames_ff - HF_BITS'(1));
            pend_in        = 1'b0;
            state_in       = S_DONE;
            if (id_ok && in_zone) begin
               this_in[tgt] = 1'b1;
            end
            priority if (!id_ok || !newly) begin
               res_halt_in = 1'b0;
            end else if (halt_frames_ff == '0) begin
               res_halt_in = 1'b1;
            end else if (WIDE_BITS'(halt_frames_ff) > WIDE_BITS'(cnt_new)) begin
               res_halt_in = 1'b0;
            end else if (halt_frames_ff == HF_BITS'(1)) begin
               // only the newest box itself
               res_halt_in = 1'b1;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (pend_ff && cmp_fail) begin
               res_halt_in = 1'b0;
               state_in    = S_DONE;
            end else if (left_ff == '0) begin
               res_halt_in = 1'b1;
               state_in    = S_DONE;
            end else begin
               ctl.box_rd_en = 1'b1;
               slot_in       = (slot_ff == '0) ? SLOT_BITS'(MAX_HALT_FRAMES - 1)
                               : slot_ff - SLOT_BITS'(1);
               left_in       = left_ff - COUNT_BITS'(1);
               pend_in       = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = '{echo_id: item_ff.target_id, in_region: res_inside_ff,
                                halt_event: res_halt_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         this_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         this_ff      <= this_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      slot_ff       <= slot_in;
      left_ff       <= left_in;
      res_inside_ff <= res_inside_in;
      res_halt_ff   <= res_halt_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ASSERT_NEXT(a_accept_to_meta, req_fire, state_ff == S_META, "accept did not start lookup")
   `ASSERT_SAME(a_halt_needs_region, rsp_valid_ff, !rsp_ff.halt_event || rsp_ff.in_region, "halt outside region")
   `ASSERT_SAME(a_scan_bound, state_ff == S_SCAN, 32'(left_ff) < MAX_HALT_FRAMES, "scan count overrun")
   `ASSERT_NEXT(a_done_loads, (state_ff == S_DONE) && !rsp_stall, rsp_valid_ff, "result not loaded")

endmodule
